### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/mp2d_pkg.sv
// ---------------------------------------------------------------------------
// Max pool plane package
// Shared types, register indexes and float constants.
// ---------------------------------------------------------------------------
package mp2d_pkg;

  localparam logic [31:0] NegInfBits = 32'hFF80_0000;

  localparam logic [2:0] RegInHeight = 3'd0;
  localparam logic [2:0] RegInWidth  = 3'd1;
  localparam logic [2:0] RegKernelH  = 3'd2;
  localparam logic [2:0] RegKernelW  = 3'd3;
  localparam logic [2:0] RegStrideH  = 3'd4;
  localparam logic [2:0] RegStrideW  = 3'd5;
  localparam logic [2:0] RegPadTop   = 3'd6;
  localparam logic [2:0] RegPadLeft  = 3'd7;

  typedef enum logic [2:0] {
    StIdle,
    StSpan,
    StRead,
    StLast,
    StDone
  } state_e;

  // True when a is a number strictly greater than b in IEEE order.
  function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    logic a_zero;
    logic b_zero;
    logic res;
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    if (a_nan || b_nan || (a_zero && b_zero)) begin
      res = 1'b0;
    end else if (a[31] != b[31]) begin
      res = b[31];
    end else if (!a[31]) begin
      res = a[30:0] > b[30:0];
    end else begin
      res = a[30:0] < b[30:0];
    end
    return res;
  endfunction

endpackage

### sv/mp2d_span.sv
// ---------------------------------------------------------------------------
// Max pool window span
// Clamped window bounds along one axis, registered.
// ---------------------------------------------------------------------------
module mp2d_span import mp2d_pkg::*; #(
  parameter int Limit = 64
) (
  input  logic        clk_i,
  input  logic        load_i,
  input  logic [6:0]  pos_i,
  input  logic [6:0]  stride_i,
  input  logic [5:0]  pad_i,
  input  logic [6:0]  kern_i,
  input  logic [6:0]  size_i,
  output logic [15:0] lo_o,
  output logic [15:0] hi_o,
  output logic        ok_o
);

  localparam logic [15:0] LimitW = 16'(Limit);

  logic signed [16:0] start_s;
  logic signed [16:0] end_s;
  logic [15:0]        extent;
  logic [15:0]        lo_d;
  logic [15:0]        hi_d;
  logic [15:0]        lo_q;
  logic [15:0]        hi_q;
  logic               ok_q;

  always_comb begin
    extent  = ({9'd0, size_i} < LimitW) ? {9'd0, size_i} : LimitW;
    start_s = $signed({3'd0, {7'd0, pos_i} * {7'd0, stride_i}}) - $signed({11'd0, pad_i});
    end_s   = start_s + $signed({10'd0, kern_i});
    lo_d    = start_s[16] ? 16'd0 : start_s[15:0];
    hi_d    = end_s[16] ? 16'd0 :
              ((end_s[15:0] > extent) ? extent : end_s[15:0]);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      ok_q <= !end_s[16] && (lo_d < hi_d);
    end
  end

  assign lo_o = lo_q;
  assign hi_o = hi_q;
  assign ok_o = ok_q;

endmodule

### sv/max_pool_2d_plane_core.sv
// ---------------------------------------------------------------------------
// Max pool plane core
// Pixel store with a sequenced window maximum over one shared comparator.
// ---------------------------------------------------------------------------
// Usage: pulse start_i while busy_o is low. With req_type_i low the beat
// writes pixel_bits_i at (pixel_row_i, pixel_col_i); rows or columns past
// the store are dropped. With req_type_i high the beat queries output
// (out_row_i, out_col_i) and one result appears on pool_bits_o and
// window_empty_o, flagged by done_o for a single cycle.
// A write leaves busy_o low. A query holds busy_o high while the
// sequencer computes the window bounds, reads the clamped window's pixels
// in turn through the single store read port and comparator, and
// finishes through the last and done states. An extra seat step loads the
// window start when the window does not start at row 0 and column 0.
// done_o is high in the first idle cycle.
// An empty window answers with zero and the flag.
// Configuration writes on cfg_valid_i/cfg_ready_o are taken while idle.
// Reset returns the registers to their defaults and idles the sequencer;
// the store is not cleared. The receiver cannot stall: done_o is a strobe.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module max_pool_2d_plane_core import mp2d_pkg::*; #(
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WIDTH  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        req_type_i,
  input  logic [5:0]  pixel_row_i,
  input  logic [5:0]  pixel_col_i,
  input  logic [31:0] pixel_bits_i,
  input  logic [6:0]  out_row_i,
  input  logic [6:0]  out_col_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  output logic        done_o,
  output logic [31:0] pool_bits_o,
  output logic        window_empty_o
);

  localparam int RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int Depth = 2 ** (RowW + ColW);

  logic [31:0] store_q [Depth];

  logic [6:0] in_height_q, in_width_q, kernel_h_q, kernel_w_q;
  logic [6:0] stride_h_q, stride_w_q;
  logic [5:0] pad_top_q, pad_left_q;

  state_e state_q, state_d;
  logic [6:0]  orow_q, ocol_q;
  logic [15:0] r0, r1, c0, c1;
  logic        rok, cok;
  logic [15:0] r_q, c_q;
  logic [31:0] max_q, rd_q;
  logic        rd_v_q;
  logic [31:0] res_bits_q;
  logic        res_empty_q;
  logic        done_q;
  logic        accept;
  logic        wr_en;
  logic        last_pix;
  logic        seat;
  logic [31:0] max_n;

  assign accept = start_i && !busy_o;
  assign wr_en  = accept && !req_type_i && (32'(pixel_row_i) < 32'(MAX_HEIGHT))
                  && (32'(pixel_col_i) < 32'(MAX_WIDTH));
  assign last_pix = (r_q == r1 - 16'd1) && (c_q == c1 - 16'd1);
  assign seat = (state_q == StRead) && !rd_v_q && (r_q == 16'd0) && (c_q == 16'd0)
                && ((r0 != 16'd0) || (c0 != 16'd0));

  mp2d_span #(.Limit(MAX_HEIGHT)) u_row (
    .clk_i, .load_i(state_q == StSpan), .pos_i(orow_q), .stride_i(stride_h_q),
    .pad_i(pad_top_q), .kern_i(kernel_h_q), .size_i(in_height_q),
    .lo_o(r0), .hi_o(r1), .ok_o(rok)
  );

  mp2d_span #(.Limit(MAX_WIDTH)) u_col (
    .clk_i, .load_i(state_q == StSpan), .pos_i(ocol_q), .stride_i(stride_w_q),
    .pad_i(pad_left_q), .kern_i(kernel_w_q), .size_i(in_width_q),
    .lo_o(c0), .hi_o(c1), .ok_o(cok)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[{RowW'(pixel_row_i), ColW'(pixel_col_i)}] <= pixel_bits_i;
    end
    rd_q <= store_q[{r_q[RowW-1:0], c_q[ColW-1:0]}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q <= 7'd64;
      in_width_q  <= 7'd64;
      kernel_h_q  <= 7'd2;
      kernel_w_q  <= 7'd2;
      stride_h_q  <= 7'd2;
      stride_w_q  <= 7'd2;
      pad_top_q   <= 6'd0;
      pad_left_q  <= 6'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegInHeight: in_height_q <= cfg_data_i;
        RegInWidth:  in_width_q  <= cfg_data_i;
        RegKernelH:  kernel_h_q  <= cfg_data_i;
        RegKernelW:  kernel_w_q  <= cfg_data_i;
        RegStrideH:  stride_h_q  <= cfg_data_i;
        RegStrideW:  stride_w_q  <= cfg_data_i;
        RegPadTop:   pad_top_q   <= cfg_data_i[5:0];
        RegPadLeft:  pad_left_q  <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (accept && req_type_i) state_d = StSpan;
      StSpan: state_d = StRead;
      StRead: if (!(rok && cok) || (last_pix && !seat)) state_d = StLast;
      StLast: state_d = StDone;
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign max_n = (rd_v_q && fp_gt(rd_q, max_q)) ? rd_q : max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      done_q  <= 1'b0;
      rd_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == StDone);
      rd_v_q  <= (state_q == StRead) && rok && cok && !seat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      orow_q <= out_row_i;
      ocol_q <= out_col_i;
    end
    unique case (state_q)
      StSpan: begin
        max_q <= NegInfBits;
      end
      StRead: max_q <= max_n;
      StLast: max_q <= max_n;
      StDone: begin
        max_q <= max_n;
        res_empty_q <= !(rok && cok);
        res_bits_q  <= (rok && cok) ? max_n : 32'd0;
      end
      default: ;
    endcase
    if (state_q == StSpan) begin
      r_q <= 16'd0;
      c_q <= 16'd0;
    end else if (seat) begin
      r_q <= r0;
      c_q <= c0;
    end else if (state_q == StRead) begin
      if (c_q == c1 - 16'd1) begin
        c_q <= c0;
        r_q <= r_q + 16'd1;
      end else begin
        c_q <= c_q + 16'd1;
      end
    end
  end

  assign busy_o         = (state_q != StIdle);
  assign cfg_ready_o    = (state_q == StIdle);
  assign done_o         = done_q;
  assign pool_bits_o    = res_bits_q;
  assign window_empty_o = res_empty_q;

  `ASSERT_NEXT(a_done_after, clk_i, rst_ni, state_q == StDone, done_o)
  `ASSERT_IMPL(a_done_idle, clk_i, rst_ni, done_o, !busy_o || state_q == StSpan)
  `ASSERT_IMPL(a_empty_zero, clk_i, rst_ni, done_o && window_empty_o, pool_bits_o == 32'd0)

endmodule

### sim/max_pool_2d_plane_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Max pool plane core testbench
// Loads a corner block of the pixel store, then runs directed and random
// write and query beats under many register settings. Each query result is
// checked against a behavioral window maximum kept in the testbench.
// ---------------------------------------------------------------------------
module max_pool_2d_plane_core_test import mp2d_pkg::*; ();

  localparam int Rows  = 64;
  localparam int Cols  = 64;
  localparam int Block = 16;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic        req_type_i;
  logic [5:0]  pixel_row_i;
  logic [5:0]  pixel_col_i;
  logic [31:0] pixel_bits_i;
  logic [6:0]  out_row_i;
  logic [6:0]  out_col_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [6:0]  cfg_data_i;
  logic        done_o;
  logic [31:0] pool_bits_o;
  logic        window_empty_o;

  max_pool_2d_plane_core #(.MAX_HEIGHT(Rows), .MAX_WIDTH(Cols)) u_dut (.*);

  typedef struct packed {
    logic [31:0] bits;
    logic        empty;
  } pool_res_t;

  logic [31:0] plane_shadow [Rows*Cols];
  int          reg_shadow   [8];
  pool_res_t   pending_pools [$];
  int          n_errors;
  int          n_writes;
  int          n_queries;
  int          n_empty;
  int          n_cfg;
  bit          no_gaps;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("FAIL max_pool_2d_plane_core");
    $finish;
  end

  // Ordered key for IEEE compare; both zeros map to one key.
  function automatic logic [32:0] float_key(input logic [31:0] b);
    if (b[30:0] == 31'd0) begin
      return {1'b1, 32'h8000_0000};
    end
    if (b[31]) begin
      return {1'b1, ~b};
    end
    return {1'b1, b | 32'h8000_0000};
  endfunction

  function automatic bit is_nan(input logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
  endfunction

  function automatic bit axis_span(input int pos, input int stride, input int pad,
                                   input int kern, input int size, input int limit,
                                   output int lo, output int hi);
    int extent;
    extent = (size < limit) ? size : limit;
    lo = pos * stride - pad;
    hi = lo + kern;
    if (lo < 0) lo = 0;
    if (hi > extent) hi = extent;
    return lo < hi;
  endfunction

  function automatic pool_res_t window_max(input int orow, input int ocol);
    pool_res_t res;
    int r0, r1, c0, c1;
    bit rows_ok, cols_ok;
    logic [31:0] v;
    rows_ok = axis_span(orow, reg_shadow[RegStrideH], reg_shadow[RegPadTop],
                        reg_shadow[RegKernelH], reg_shadow[RegInHeight], Rows, r0, r1);
    cols_ok = axis_span(ocol, reg_shadow[RegStrideW], reg_shadow[RegPadLeft],
                        reg_shadow[RegKernelW], reg_shadow[RegInWidth], Cols, c0, c1);
    if (!rows_ok || !cols_ok) begin
      res.bits = 32'd0;
      res.empty = 1'b1;
      return res;
    end
    res.bits = NegInfBits;
    res.empty = 1'b0;
    for (int r = r0; r < r1; r++) begin
      for (int c = c0; c < c1; c++) begin
        v = plane_shadow[r*Cols + c];
        if (!is_nan(v) && float_key(v) > float_key(res.bits)) res.bits = v;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 11))
      0: return 32'h7F80_0000;
      1: return 32'hFF80_0000;
      2: return 32'h7FC0_0000 | $urandom_range(0, 32'h3F_FFFF);
      3: return 32'hFFC0_0001;
      4: return 32'h0000_0000;
      5: return 32'h8000_0000;
      6: return 32'h7F7F_FFFF;
      7: return {1'b1, 8'h00, 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_gap();
    int n;
    n = 0;
    if (!no_gaps) begin
      case ($urandom_range(0, 19))
        0: n = $urandom_range(10, 40);
        1, 2, 3, 4, 5: n = $urandom_range(1, 3);
        default: n = 0;
      endcase
    end
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_beat(input logic req, input logic [5:0] row, input logic [5:0] col,
                           input logic [31:0] bits, input logic [6:0] orow,
                           input logic [6:0] ocol);
    idle_gap();
    start_i      <= 1'b1;
    req_type_i   <= req;
    pixel_row_i  <= row;
    pixel_col_i  <= col;
    pixel_bits_i <= bits;
    out_row_i    <= orow;
    out_col_i    <= ocol;
    do @(posedge clk_i); while (busy_o);
    if (req) begin
      pending_pools.push_back(window_max(orow, ocol));
      n_queries++;
    end else begin
      plane_shadow[row*Cols + col] = bits;
      n_writes++;
    end
  endtask

  task automatic write_pixel(input int row, input int col, input logic [31:0] bits);
    send_beat(1'b0, row[5:0], col[5:0], bits, 7'($urandom), 7'($urandom));
  endtask

  task automatic query_pool(input int orow, input int ocol);
    send_beat(1'b1, 6'($urandom), 6'($urandom), $urandom, orow[6:0], ocol[6:0]);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [6:0] data);
    start_i <= 1'b0;
    while (pending_pools.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    reg_shadow[idx] = (idx == RegPadTop || idx == RegPadLeft) ? int'(data[5:0]) : int'(data);
    n_cfg++;
  endtask

  task automatic set_geometry(input int h, input int w, input int kh, input int kw,
                              input int sh, input int sw, input int pt, input int pl);
    write_reg(RegInHeight, h[6:0]);
    write_reg(RegInWidth, w[6:0]);
    write_reg(RegKernelH, kh[6:0]);
    write_reg(RegKernelW, kw[6:0]);
    write_reg(RegStrideH, sh[6:0]);
    write_reg(RegStrideW, sw[6:0]);
    write_reg(RegPadTop, pt[6:0]);
    write_reg(RegPadLeft, pl[6:0]);
  endtask

  always @(posedge clk_i) begin
    pool_res_t want;
    if (rst_ni && done_o) begin
      if (pending_pools.size() == 0) begin
        $display("%0t: unexpected result bits=%h empty=%b", $time, pool_bits_o,
                 window_empty_o);
        n_errors++;
      end else begin
        want = pending_pools.pop_front();
        if (want.empty) n_empty++;
        if (pool_bits_o !== want.bits) begin
          $display("%0t: pool_bits expected %h actual %h", $time, want.bits, pool_bits_o);
          n_errors++;
        end
        if (window_empty_o !== want.empty) begin
          $display("%0t: window_empty expected %b actual %b", $time, want.empty,
                   window_empty_o);
          n_errors++;
        end
      end
    end
  end

  task automatic test_load_plane();
    no_gaps = 1'b1;
    for (int r = 0; r < Block; r++) begin
      for (int c = 0; c < Block; c++) write_pixel(r, c, rand_pixel());
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_reset_defaults();
    query_pool(0, 0);
    query_pool(7, 7);
    query_pool(32, 5);
    query_pool(127, 127);
  endtask

  task automatic test_directed();
    write_pixel(0, 0, 32'h7FC0_0001);
    write_pixel(63, 63, 32'h7F80_0000);
    write_pixel(0, 1, 32'hFF80_0000);
    write_pixel(1, 0, 32'h8000_0000);
    write_pixel(1, 1, 32'h0000_0000);
    set_geometry(127, 127, 1, 1, 1, 1, 0, 0);
    query_pool(0, 0);
    query_pool(63, 63);
    query_pool(64, 0);
    set_geometry(64, 64, 2, 2, 0, 0, 0, 0);
    query_pool(5, 9);
    set_geometry(0, 64, 2, 2, 1, 1, 0, 0);
    query_pool(0, 0);
    set_geometry(64, 64, 0, 3, 1, 1, 0, 0);
    query_pool(1, 1);
    set_geometry(127, 127, 3, 3, 127, 127, 63, 63);
    query_pool(0, 0);
    query_pool(1, 1);
    query_pool(127, 127);
    set_geometry(16, 16, 127, 127, 1, 1, 63, 63);
    query_pool(0, 0);
  endtask

  task automatic test_random_phases();
    int h, w, kh, kw, sh, sw, pt, pl, reach_r, reach_c;
    for (int ph = 0; ph < 8; ph++) begin
      h  = $urandom_range(1, Block);
      w  = $urandom_range(1, Block);
      kh = $urandom_range(1, 4);
      kw = $urandom_range(1, 4);
      sh = $urandom_range(1, 4);
      sw = $urandom_range(1, 4);
      pt = $urandom_range(0, 3);
      pl = $urandom_range(0, 3);
      if (ph == 7) begin
        h = $urandom_range(65, 127); w = 127; kh = $urandom_range(0, 127);
        kw = $urandom_range(0, 20); sh = $urandom_range(0, 127); sw = 0;
        pt = $urandom_range(0, 127); pl = 127;
      end
      set_geometry(h, w, kh, kw, sh, sw, pt, pl);
      no_gaps = (ph % 3 == 1);
      reach_r = (sh == 0) ? 127 : (h + pt) / sh + 1;
      reach_c = (sw == 0) ? 127 : (w + pl) / sw + 1;
      if (reach_r > 127) reach_r = 127;
      if (reach_c > 127) reach_c = 127;
      for (int i = 0; i < ((ph == 7) ? 20 : 70); i++) begin
        if ($urandom_range(0, 2) == 0) begin
          write_pixel($urandom_range(0, 63), $urandom_range(0, 63), rand_pixel());
        end else if ($urandom_range(0, 9) == 0) begin
          query_pool($urandom_range(0, 127), $urandom_range(0, 127));
        end else begin
          query_pool($urandom_range(0, reach_r), $urandom_range(0, reach_c));
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_type_i   = 1'b0;
    pixel_row_i  = '0;
    pixel_col_i  = '0;
    pixel_bits_i = '0;
    out_row_i    = '0;
    out_col_i    = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = RegInHeight;
    cfg_data_i   = '0;
    n_errors = 0; n_writes = 0; n_queries = 0; n_empty = 0; n_cfg = 0;
    no_gaps = 1'b0;
    reg_shadow[RegInHeight] = 64;
    reg_shadow[RegInWidth]  = 64;
    reg_shadow[RegKernelH]  = 2;
    reg_shadow[RegKernelW]  = 2;
    reg_shadow[RegStrideH]  = 2;
    reg_shadow[RegStrideW]  = 2;
    reg_shadow[RegPadTop]   = 0;
    reg_shadow[RegPadLeft]  = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_load_plane();
    test_reset_defaults();
    test_directed();
    test_random_phases();
    start_i <= 1'b0;
    while (pending_pools.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d pixel write beats, %0d query beats (%0d empty windows),",
             n_writes, n_queries, n_empty);
    $display("and %0d register writes over directed and random geometries.", n_cfg);
    if (n_errors == 0) begin
      $display("PASS max_pool_2d_plane_core");
    end else begin
      $display("FAIL max_pool_2d_plane_core");
    end
    $finish;
  end

endmodule
